// ===== src/aoc_pkg.sv =====
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared types and constants of the accelerometer offset calibration block.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int RAW_W       = 12;   // one raw axis sample, signed
    localparam int ACC_W       = 13;   // corrected axis value, signed
    localparam int TAKEN_W     = 5;    // reported sample count
    localparam int QUEUE_DEPTH = 2;
    localparam int ONE_G       = 1024;
    localparam int S_TDATA_W   = 48;   // six raw bytes
    localparam int S_TUSER_W   = 2;    // kind
    localparam int M_TDATA_W   = 48;   // 3 x 13 + 5 = 44 bits, padded
    localparam int M_TUSER_W   = 1;    // cal_done

    // kind codes on the input tuser
    localparam logic [S_TUSER_W-1:0] KIND_MEASURE = 2'd0;
    localparam logic [S_TUSER_W-1:0] KIND_CAL     = 2'd1;
    localparam logic [S_TUSER_W-1:0] KIND_CLEAR   = 2'd2;

    typedef enum logic [1:0] {
        OP_MEASURE,
        OP_CAL,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [RAW_W-1:0] x;
        logic signed [RAW_W-1:0] y;
        logic signed [RAW_W-1:0] z;
    } t_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_x;
        logic signed [ACC_W-1:0] acc_y;
        logic signed [ACC_W-1:0] acc_z;
        logic [TAKEN_W-1:0]      taken;
        logic                    done;
    } t_result;

    // axis_map register, bit0 is swap
    typedef struct packed {
        logic neg_z;
        logic neg_y;
        logic neg_x;
        logic swap;
    } t_axis_map;

endpackage

// ===== src/aoc_front.sv =====
// ----------------------------------------------------------------------------
// aoc_front
// Classifies the item kind and unpacks the six raw bytes into 12-bit samples.
// ----------------------------------------------------------------------------
module aoc_front import aoc_pkg::*; (
    input  logic [S_TUSER_W-1:0] i_kind,
    input  logic [S_TDATA_W-1:0] i_bytes,
    output t_item                o_item
);

    t_op w_op;

    always_comb begin
        case (i_kind)
            KIND_MEASURE: w_op = OP_MEASURE;
            KIND_CAL:     w_op = OP_CAL;
            KIND_CLEAR:   w_op = OP_CLEAR;
            default:      w_op = OP_NOP;
        endcase
    end

    // little-endian word, arithmetic shift right by 4 = top 12 bits
    assign o_item.op = w_op;
    assign o_item.x  = signed'(i_bytes[15:4]);
    assign o_item.y  = signed'(i_bytes[31:20]);
    assign o_item.z  = signed'(i_bytes[47:36]);

endmodule

// ===== src/aoc_queue.sv =====
// ----------------------------------------------------------------------------
// aoc_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module aoc_queue import aoc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_count != (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/aoc_back.sv =====
// ----------------------------------------------------------------------------
// aoc_back
// Executes items: offset correction and axis map, calibration sums, the
// divide-by-sample-count via reciprocal multiply, and the output register.
// ----------------------------------------------------------------------------
module aoc_back import aoc_pkg::*; #(
    parameter int CAL_SAMPLES = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    localparam int LOG_N   = $clog2(CAL_SAMPLES);
    localparam int SUM_W   = RAW_W + LOG_N;
    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int SHIFT   = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / N): exact floor division for any SUM_W-bit magnitude
    localparam longint RECIP_L =
        ((longint'(1) << SHIFT) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_L);
    localparam logic [CNT_W-1:0]   CNT_LIMIT  = CNT_W'(CAL_SAMPLES);
    localparam logic [TAKEN_W-1:0] DONE_TAKEN = TAKEN_W'(CAL_SAMPLES);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_FIN
    } t_state;

    t_state                  r_state,    n_state;
    t_axis_map               r_map;
    logic signed [RAW_W-1:0] r_off_x,    n_off_x;
    logic signed [RAW_W-1:0] r_off_y,    n_off_y;
    logic signed [RAW_W-1:0] r_off_z,    n_off_z;
    logic signed [SUM_W-1:0] r_sum_x,    n_sum_x;
    logic signed [SUM_W-1:0] r_sum_y,    n_sum_y;
    logic signed [SUM_W-1:0] r_sum_z,    n_sum_z;
    logic [CNT_W-1:0]        r_cnt,      n_cnt;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out,      n_out;
    logic [SUM_W-1:0]        r_mag_x,    n_mag_x;
    logic [SUM_W-1:0]        r_mag_y,    n_mag_y;
    logic [SUM_W-1:0]        r_mag_z,    n_mag_z;
    logic                    r_neg_x,    n_neg_x;
    logic                    r_neg_y,    n_neg_y;
    logic                    r_neg_z,    n_neg_z;
    logic                    r_zpos,     n_zpos;
    logic [RAW_W-1:0]        r_quo_x,    n_quo_x;
    logic [RAW_W-1:0]        r_quo_y,    n_quo_y;
    logic [RAW_W-1:0]        r_quo_z,    n_quo_z;

    logic signed [SUM_W-1:0] w_acc_x, w_acc_y, w_acc_z;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic signed [ACC_W-1:0] w_dx, w_dy, w_dz, w_mx, w_my;
    logic signed [ACC_W-1:0] w_ax, w_ay, w_az;
    logic [PROD_W-1:0]       w_prod_x, w_prod_y, w_prod_z;
    logic signed [ACC_W-1:0] w_qx, w_qy, w_qz;
    logic signed [ACC_W-1:0] w_fx, w_fy, w_fz_avg, w_fz;

    assign o_pop    = (r_state == ST_RUN) && i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // running sums with this sample, count including this sample
    assign w_acc_x   = r_sum_x + SUM_W'(i_item.x);
    assign w_acc_y   = r_sum_y + SUM_W'(i_item.y);
    assign w_acc_z   = r_sum_z + SUM_W'(i_item.z);
    assign w_cnt_inc = r_cnt + CNT_W'(1);

    // measure path: subtract offsets, then swap, then negate
    assign w_dx = ACC_W'(i_item.x) - ACC_W'(r_off_x);
    assign w_dy = ACC_W'(i_item.y) - ACC_W'(r_off_y);
    assign w_dz = ACC_W'(i_item.z) - ACC_W'(r_off_z);
    assign w_mx = r_map.swap ? w_dy : w_dx;
    assign w_my = r_map.swap ? w_dx : w_dy;
    assign w_ax = r_map.neg_x ? -w_mx : w_mx;
    assign w_ay = r_map.neg_y ? -w_my : w_my;
    assign w_az = r_map.neg_z ? -w_dz : w_dz;

    // reciprocal multiply on registered magnitudes
    assign w_prod_x = PROD_W'(r_mag_x) * PROD_W'(RECIP);
    assign w_prod_y = PROD_W'(r_mag_y) * PROD_W'(RECIP);
    assign w_prod_z = PROD_W'(r_mag_z) * PROD_W'(RECIP);

    // restore sign (truncating toward zero); Z drops by one g if its sum is positive, else rises by one g
    assign w_qx     = signed'({1'b0, r_quo_x});
    assign w_qy     = signed'({1'b0, r_quo_y});
    assign w_qz     = signed'({1'b0, r_quo_z});
    assign w_fx     = r_neg_x ? -w_qx : w_qx;
    assign w_fy     = r_neg_y ? -w_qy : w_qy;
    assign w_fz_avg = r_neg_z ? -w_qz : w_qz;
    assign w_fz     = r_zpos ? w_fz_avg - ACC_W'(ONE_G) : w_fz_avg + ACC_W'(ONE_G);

    always_comb begin
        n_state     = r_state;
        n_off_x     = r_off_x;
        n_off_y     = r_off_y;
        n_off_z     = r_off_z;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_sum_z     = r_sum_z;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        n_mag_x     = r_mag_x;
        n_mag_y     = r_mag_y;
        n_mag_z     = r_mag_z;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_neg_z     = r_neg_z;
        n_zpos      = r_zpos;
        n_quo_x     = r_quo_x;
        n_quo_y     = r_quo_y;
        n_quo_z     = r_quo_z;

        case (r_state)
            ST_RUN: begin
                if (o_pop) begin
                    n_out.acc_x = ACC_W'(r_off_x);
                    n_out.acc_y = ACC_W'(r_off_y);
                    n_out.acc_z = ACC_W'(r_off_z);
                    n_out.taken = TAKEN_W'(r_cnt);
                    n_out.done  = 1'b0;
                    n_out_valid = 1'b1;
                    case (i_item.op)
                        OP_MEASURE: begin
                            n_out.acc_x = w_ax;
                            n_out.acc_y = w_ay;
                            n_out.acc_z = w_az;
                        end
                        OP_CAL: begin
                            if (w_cnt_inc >= CNT_LIMIT) begin
                                // run complete: multiply in ST_MUL, then finish in ST_FIN
                                n_mag_x     = w_acc_x[SUM_W-1] ? -w_acc_x : w_acc_x;
                                n_mag_y     = w_acc_y[SUM_W-1] ? -w_acc_y : w_acc_y;
                                n_mag_z     = w_acc_z[SUM_W-1] ? -w_acc_z : w_acc_z;
                                n_neg_x     = w_acc_x[SUM_W-1];
                                n_neg_y     = w_acc_y[SUM_W-1];
                                n_neg_z     = w_acc_z[SUM_W-1];
                                n_zpos      = !w_acc_z[SUM_W-1] && (w_acc_z != '0);
                                n_sum_x     = '0;
                                n_sum_y     = '0;
                                n_sum_z     = '0;
                                n_cnt       = '0;
                                n_out_valid = 1'b0;
                                n_state     = ST_MUL;
                            end else begin
                                n_sum_x     = w_acc_x;
                                n_sum_y     = w_acc_y;
                                n_sum_z     = w_acc_z;
                                n_cnt       = w_cnt_inc;
                                n_out.taken = TAKEN_W'(w_cnt_inc);
                            end
                        end
                        OP_CLEAR: begin
                            n_off_x     = '0;
                            n_off_y     = '0;
                            n_off_z     = '0;
                            n_sum_x     = '0;
                            n_sum_y     = '0;
                            n_sum_z     = '0;
                            n_cnt       = '0;
                            n_out.acc_x = '0;
                            n_out.acc_y = '0;
                            n_out.acc_z = '0;
                            n_out.taken = '0;
                            n_out.done  = 1'b1;
                        end
                        default: begin
                            // unused kind: report state, change nothing
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_quo_x = w_prod_x[SHIFT +: RAW_W];
                n_quo_y = w_prod_y[SHIFT +: RAW_W];
                n_quo_z = w_prod_z[SHIFT +: RAW_W];
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // output register is empty here: it was free when the item popped
                n_off_x     = w_fx[RAW_W-1:0];
                n_off_y     = w_fy[RAW_W-1:0];
                n_off_z     = w_fz[RAW_W-1:0];
                n_out.acc_x = ACC_W'(signed'(w_fx[RAW_W-1:0]));
                n_out.acc_y = ACC_W'(signed'(w_fy[RAW_W-1:0]));
                n_out.acc_z = ACC_W'(signed'(w_fz[RAW_W-1:0]));
                n_out.taken = DONE_TAKEN;
                n_out.done  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_mag_z <= n_mag_z;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_neg_z <= n_neg_z;
        r_zpos  <= n_zpos;
        r_quo_x <= n_quo_x;
        r_quo_y <= n_quo_y;
        r_quo_z <= n_quo_z;
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_map       <= '0;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_off_z     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_off_x     <= n_off_x;
            r_off_y     <= n_off_y;
            r_off_z     <= n_off_z;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_z     <= n_sum_z;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_map <= t_axis_map'(i_cfg_wdata);
            end
        end
    end

endmodule

// ===== src/accel_offset_calibration.sv =====
// ----------------------------------------------------------------------------
// accel_offset_calibration
// Accelerometer offset correction, axis remap and offset calibration.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: 6 raw bytes, tuser: kind
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: x,y,z,count, tuser: done
//  cfg       in         i_cfg_we (no wait)            i_cfg_wdata: axis_map
//
// One transaction per cycle sustained while m_axis is ready and no run completes.
// Items pass the queue, then the output register. Ending a calibration run holds
// the back end for a reciprocal multiply, then a sign and one-g adjust.
// The 2-entry queue decouples input from the back end; m_axis stalls back up
// into the queue, then s_axis_tready drops.
// i_rst_n is synchronous, active low: clears offsets, sums, count, axis_map.
//
module accel_offset_calibration import aoc_pkg::*; #(
    parameter int CAL_SAMPLES = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // x_low[7:0], x_high[15:8], y_low[23:16], y_high[31:24],
    // z_low[39:32], z_high[47:40]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    // master side
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // acc_x[12:0], acc_y[25:13], acc_z[38:26], samples_taken[43:39], zero[47:44]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // cal_done[0]
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_wdata
);

    t_item   w_front_item;
    t_item   w_queue_item;
    logic    w_queue_valid;
    logic    w_pop;
    t_result w_res;

    // front: classify kind, unpack raw bytes
    aoc_front u_front (
        .i_kind  (s_axis_tuser),
        .i_bytes (s_axis_tdata),
        .o_item  (w_front_item)
    );

    // queue: lets input and execution stall independently
    aoc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (w_front_item),
        .o_ready (s_axis_tready),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item),
        .i_pop   (w_pop)
    );

    // back end: state, arithmetic, output register
    aoc_back #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_queue_valid),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .o_result    (w_res),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = M_TDATA_W'({w_res.taken, w_res.acc_z, w_res.acc_y, w_res.acc_x});
    assign m_axis_tuser = w_res.done;

endmodule

// ===== src/aoc_checker.sv =====
// ----------------------------------------------------------------------------
// aoc_checker
// Port-level checks of the offset calibration block, bound to the top level.
// ----------------------------------------------------------------------------
module aoc_checker import aoc_pkg::*; #(
    parameter int CAL_SAMPLES = 20
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam logic [TAKEN_W-1:0] DONE_TAKEN = TAKEN_W'(CAL_SAMPLES);
    localparam logic CLEAR_DISTINCT = ((CAL_SAMPLES % 32) != 0);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output transaction changed while stalled");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // done only on a run completion or a clear
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[43:39] == '0) || (m_axis_tdata[43:39] == DONE_TAKEN))
        else $error("done with unexpected sample count");

    // a clear reports zero offsets
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && CLEAR_DISTINCT &&
            (m_axis_tdata[43:39] == '0) |-> (m_axis_tdata[38:0] == '0))
        else $error("clear did not report zero offsets");

endmodule

bind accel_offset_calibration aoc_checker #(
    .CAL_SAMPLES (CAL_SAMPLES)
) u_aoc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
